/* src/smpc_pkg.sv */
// ----------------------------------------------------------------------------
// smpc_pkg
// Shared types and constants of the shadow memory poison checker: field
// widths, shadow byte codes, request kinds, state encodings and the
// command and status bundles between the top level and the shadow engine.
// ----------------------------------------------------------------------------
package smpc_pkg;

   localparam int unsigned WINDOW_BYTES_DEF = 65536;
   localparam int unsigned MAX_RANGE_DEF    = 4096;

   localparam int unsigned GRANULE_SHIFT = 3;
   localparam int unsigned OFF_W         = 3;
   localparam int unsigned ADDR_W        = 16;
   localparam int unsigned LEN_W         = 13;
   localparam int unsigned SUM_W         = 17;
   localparam int unsigned GRAN_W        = SUM_W - GRANULE_SHIFT;
   localparam int unsigned SHADOW_W      = 8;

   localparam logic [SHADOW_W-1:0] POISON_MARK = 8'hF7;

   localparam logic KIND_POISON = 1'b0;
   localparam logic KIND_CHECK  = 1'b1;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_WALK,
      TOP_FINISH
   } top_state_type;

   typedef enum logic [1:0] {
      ENG_CLEAR,
      ENG_IDLE,
      ENG_WALK,
      ENG_DRAIN
   } eng_state_type;

   typedef struct packed {
      logic              start;
      logic              kind;
      logic              single;
      logic              end_real;
      logic [GRAN_W-1:0] first_g;
      logic [GRAN_W-1:0] last_g;
      logic [OFF_W-1:0]  bo;
      logic [OFF_W-1:0]  eo;
      logic [OFF_W-1:0]  hoff;
   } cmd_type;

   typedef struct packed {
      logic              ready;
      logic              done;
      logic              found;
      logic [ADDR_W-1:0] first;
   } status_type;

endpackage

/* src/shadow_memory_poison_check_top.sv */
// ----------------------------------------------------------------------------
// shadow_memory_poison_check_top
// Shadow memory poison tracker: one shadow byte per 8-byte granule of the
// window. Poison transfers mark a byte range unaddressable, check transfers
// report the first poisoned byte of a range.
//
//   channel | dir | tdata (low bit up)                              | tuser
//   req_    | in  | address[15:0], length[28:16], zero pad          | kind
//   rsp_    | out | found_poisoned[0], first_poisoned[16:1],         | -
//           |     | range_error[17], zero pad                       |
//
// A walked item visits the shadow granules it touches one after another
// (single read and write port of the shadow store). A check stops at the
// first poisoned byte; an empty or rejected item is not walked.
// After reset the store is cleared, one granule a cycle, with req_tready low.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module shadow_memory_poison_check_top #(
   parameter int unsigned WINDOW_BYTES = smpc_pkg::WINDOW_BYTES_DEF,
   parameter int unsigned MAX_RANGE    = smpc_pkg::MAX_RANGE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // address[15:0], length[28:16]
   input  logic [0:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // found_poisoned, first_poisoned[16:1], range_error
);

   localparam int unsigned SHADOW_DEPTH =
      (WINDOW_BYTES + (1 << smpc_pkg::GRANULE_SHIFT) - 1) >> smpc_pkg::GRANULE_SHIFT;

   smpc_pkg::top_state_type state_ff, state_in;
   smpc_pkg::cmd_type       cmd;
   smpc_pkg::status_type    eng_status;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_found_ff, out_err_ff;
   logic [smpc_pkg::ADDR_W-1:0] out_first_ff;
   logic                        res_found_ff, res_found_in;
   logic                        res_err_ff, res_err_in;
   logic [smpc_pkg::ADDR_W-1:0] res_first_ff, res_first_in;
   logic                        out_load;

   logic                        req_accept;
   logic [smpc_pkg::ADDR_W-1:0] addr;
   logic [smpc_pkg::LEN_W-1:0]  len;
   logic [smpc_pkg::SUM_W-1:0]  stop, last_byte;
   logic [smpc_pkg::GRAN_W-1:0] bi, ei, ei_prev;
   logic                        len_zero, too_long, beyond, need_walk, end_real, single;

   smpc_shadow_engine #(
      .WINDOW_BYTES(WINDOW_BYTES)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .status(eng_status)
   );

   always_comb begin
      addr      = req_tdata[15:0];
      len       = req_tdata[28:16];
      stop      = {1'b0, addr} + {4'b0, len};
      last_byte = stop - 1'b1;
      bi        = {1'b0, addr[smpc_pkg::ADDR_W-1:smpc_pkg::GRANULE_SHIFT]};
      ei        = stop[smpc_pkg::SUM_W-1:smpc_pkg::GRANULE_SHIFT];
      ei_prev   = ei - 1'b1;
      len_zero  = (len == '0);
      too_long  = (32'(len) > 32'(MAX_RANGE));
      beyond    = (32'(stop) > 32'(WINDOW_BYTES));
      need_walk = !len_zero && !too_long && !beyond;
      single    = (bi == ei);
      end_real  = (32'(ei) < 32'(SHADOW_DEPTH)) && (stop[2:0] != '0);

      req_tready = (state_ff == smpc_pkg::TOP_IDLE) && eng_status.ready;
      req_accept = req_tvalid && req_tready;

      cmd.start    = req_accept && need_walk;
      cmd.kind     = req_tuser[0];
      cmd.single   = single;
      cmd.end_real = end_real;
      cmd.first_g  = bi;
      cmd.bo       = addr[2:0];
      cmd.eo       = stop[2:0];
      cmd.hoff     = last_byte[2:0];
      if (req_tuser[0] == smpc_pkg::KIND_CHECK) begin
         cmd.last_g = last_byte[smpc_pkg::SUM_W-1:smpc_pkg::GRANULE_SHIFT];
      end else if (single || end_real) begin
         cmd.last_g = ei;
      end else begin
         cmd.last_g = ei_prev;
      end
   end

   always_comb begin
      state_in     = state_ff;
      res_found_in = res_found_ff;
      res_first_in = res_first_ff;
      res_err_in   = res_err_ff;
      out_load     = 1'b0;

      case (state_ff)
         smpc_pkg::TOP_IDLE: begin
            if (req_accept) begin
               res_found_in = 1'b0;
               res_first_in = '0;
               res_err_in   = !len_zero && (too_long || beyond);
               state_in     = need_walk ? smpc_pkg::TOP_WALK : smpc_pkg::TOP_FINISH;
            end
         end
         smpc_pkg::TOP_WALK: begin
            if (eng_status.done) begin
               res_found_in = eng_status.found;
               res_first_in = eng_status.first;
               res_err_in   = 1'b0;
               state_in     = smpc_pkg::TOP_FINISH;
            end
         end
         smpc_pkg::TOP_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = smpc_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = smpc_pkg::TOP_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smpc_pkg::TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_found_ff <= res_found_in;
      res_first_ff <= res_first_in;
      res_err_ff   <= res_err_in;
      if (out_load) begin
         out_found_ff <= res_found_ff;
         out_first_ff <= res_first_ff;
         out_err_ff   <= res_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_err_ff, out_first_ff, out_found_ff};

endmodule

/* src/smpc_shadow_engine.sv */
// ----------------------------------------------------------------------------
// smpc_shadow_engine
// Shadow byte store with one write and one registered read port. Clears the
// store after reset, then walks the granules of one command, one granule a
// cycle: read, then modify and write back (poison) or test (check).
// ----------------------------------------------------------------------------
module smpc_shadow_engine #(
   parameter int unsigned WINDOW_BYTES = smpc_pkg::WINDOW_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  smpc_pkg::cmd_type    cmd,
   output smpc_pkg::status_type status
);

   localparam int unsigned SHADOW_DEPTH =
      (WINDOW_BYTES + (1 << smpc_pkg::GRANULE_SHIFT) - 1) >> smpc_pkg::GRANULE_SHIFT;
   localparam int unsigned IDX_W = $clog2(SHADOW_DEPTH);
   localparam int unsigned CUR_W = (IDX_W > smpc_pkg::GRAN_W) ? IDX_W : smpc_pkg::GRAN_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SHADOW_DEPTH - 1);

   logic [smpc_pkg::SHADOW_W-1:0] shadow_mem [SHADOW_DEPTH];

   smpc_pkg::eng_state_type state_ff, state_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic [CUR_W-1:0]        cur_ff, cur_in;
   logic [CUR_W-1:0]        first_ff, last_ff;
   logic                    kind_ff, single_ff, end_real_ff;
   logic [smpc_pkg::OFF_W-1:0] bo_ff, eo_ff, hoff_ff;

   logic                    p_valid_ff, p_valid_in;
   logic                    p_first_ff, p_first_in;
   logic                    p_last_ff, p_last_in;
   logic [CUR_W-1:0]        p_idx_ff;

   logic                    rd_en;
   logic [IDX_W-1:0]        rd_idx;
   logic [smpc_pkg::SHADOW_W-1:0] rd_data_ff;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_idx;
   logic [smpc_pkg::SHADOW_W-1:0] wr_data;

   logic [smpc_pkg::SHADOW_W-1:0] v, bo8, eo8, lo8, hi8, pos8, min_bo;
   logic                    v_pos, v_in_end, is_check, hit, walk_done;
   logic [smpc_pkg::OFF_W-1:0] lo3, hi3, hit_pos;
   logic [CUR_W+smpc_pkg::OFF_W-1:0] hit_addr;
   logic [smpc_pkg::SHADOW_W-1:0] poison_val;
   logic                    poison_wr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         shadow_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= shadow_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= smpc_pkg::ENG_CLEAR;
         clr_ff     <= '0;
         cur_ff     <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         cur_ff     <= cur_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_first_ff <= p_first_in;
      p_last_ff  <= p_last_in;
      p_idx_ff   <= cur_ff;
      if (cmd.start && state_ff == smpc_pkg::ENG_IDLE) begin
         first_ff    <= CUR_W'(cmd.first_g);
         last_ff     <= CUR_W'(cmd.last_g);
         kind_ff     <= cmd.kind;
         single_ff   <= cmd.single;
         end_real_ff <= cmd.end_real;
         bo_ff       <= cmd.bo;
         eo_ff       <= cmd.eo;
         hoff_ff     <= cmd.hoff;
      end
   end

   // granule stage: shadow byte of p_idx_ff is in rd_data_ff
   always_comb begin
      v        = rd_data_ff;
      bo8      = {5'b0, bo_ff};
      eo8      = {5'b0, eo_ff};
      v_pos    = !v[7] && (v != '0);
      v_in_end = v_pos && (v <= eo8);
      min_bo   = (v[7] || (v < bo8)) ? v : bo8;
      is_check = (kind_ff == smpc_pkg::KIND_CHECK);

      poison_wr  = 1'b1;
      poison_val = smpc_pkg::POISON_MARK;
      if (single_ff) begin
         poison_wr  = v_in_end;
         poison_val = (bo_ff != '0) ? min_bo : smpc_pkg::POISON_MARK;
      end else if (p_first_ff && bo_ff != '0) begin
         poison_val = (v == '0) ? bo8 : min_bo;
      end else if (p_last_ff && end_real_ff) begin
         poison_wr  = v_in_end;
      end

      lo3     = p_first_ff ? bo_ff : '0;
      hi3     = p_last_ff ? hoff_ff : '1;
      lo8     = {5'b0, lo3};
      hi8     = {5'b0, hi3};
      pos8    = (v > lo8) ? v : lo8;
      hit     = v[7] || (v_pos && pos8 <= hi8);
      hit_pos = v[7] ? lo3 : pos8[smpc_pkg::OFF_W-1:0];
      hit_addr = {p_idx_ff, hit_pos};

      walk_done = p_valid_ff && (p_last_ff || (is_check && hit));
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cur_in     = cur_ff;
      p_valid_in = 1'b0;
      p_first_in = 1'b0;
      p_last_in  = 1'b0;
      rd_en      = 1'b0;
      rd_idx     = cur_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_idx     = p_idx_ff[IDX_W-1:0];
      wr_data    = poison_val;

      if (p_valid_ff && !is_check) begin
         wr_en = poison_wr;
      end

      case (state_ff)
         smpc_pkg::ENG_CLEAR: begin
            wr_en   = 1'b1;
            wr_idx  = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = smpc_pkg::ENG_IDLE;
            end
         end
         smpc_pkg::ENG_IDLE: begin
            if (cmd.start) begin
               cur_in   = CUR_W'(cmd.first_g);
               state_in = smpc_pkg::ENG_WALK;
            end
         end
         smpc_pkg::ENG_WALK: begin
            rd_en      = 1'b1;
            p_valid_in = 1'b1;
            p_first_in = (cur_ff == first_ff);
            p_last_in  = (cur_ff == last_ff);
            cur_in     = cur_ff + 1'b1;
            if (cur_ff == last_ff) begin
               state_in = smpc_pkg::ENG_DRAIN;
            end
            if (walk_done) begin
               p_valid_in = 1'b0;
               state_in   = smpc_pkg::ENG_IDLE;
            end
         end
         smpc_pkg::ENG_DRAIN: begin
            if (walk_done) begin
               state_in = smpc_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = smpc_pkg::ENG_CLEAR;
         end
      endcase
   end

   always_comb begin
      status.ready = (state_ff == smpc_pkg::ENG_IDLE);
      status.done  = walk_done;
      status.found = is_check && hit;
      status.first = (is_check && hit) ? hit_addr[smpc_pkg::ADDR_W-1:0] : '0;
   end

endmodule
